/* src/s1icv_pkg.sv */
// Shared types and constants for the SHA-1 tag append and verify unit.
package s1icv_pkg;

  localparam logic [31:0] SHA_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  // Control bits of one request from the front to the back.
  typedef struct packed {
    logic hash;
    logic eop;
    logic vmode;
    logic short_pkt;
  } cmd_ctl_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic        fail;
    logic [31:0] drops;
  } out_item_t;

endpackage

/* src/s1icv_fifo.sv */
// Small synchronous queue used between the front, the back and the result port.
module s1icv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(do_wr) - CW'(do_rd);
    end
  end
endmodule

/* src/s1icv_front.sv */
// Front end: mode register, tag delay line and request classification.
module s1icv_front import s1icv_pkg::*; #(
  parameter int TAG_BYTES = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_packet,
  output logic                   cmd_push,
  input  logic                   cmd_full,
  output logic [7:0]             cmd_byte,
  output cmd_ctl_t               cmd_ctl,
  output logic [TAG_BYTES*8-1:0] cmd_tag
);
  localparam int FW = $clog2(TAG_BYTES + 1);
  localparam int TI = $clog2(TAG_BYTES);

  logic          mode_r;
  logic [7:0]    tag_r [TAG_BYTES];
  logic [7:0]    tag_nxt [TAG_BYTES];
  logic [FW-1:0] fill_r, fill_nxt;
  logic          accept, hash;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  always_comb begin
    tag_nxt  = tag_r;
    fill_nxt = fill_r;
    hash     = 1'b1;
    cmd_byte = in_data_byte;
    if (mode_r) begin
      if (fill_r < FW'(TAG_BYTES)) begin
        tag_nxt[fill_r[TI-1:0]] = in_data_byte;
        fill_nxt = fill_r + 1'b1;
        hash     = 1'b0;
      end else begin
        cmd_byte = tag_r[0];
        for (int j = 0; j < TAG_BYTES - 1; j++) begin
          tag_nxt[j] = tag_r[j+1];
        end
        tag_nxt[TAG_BYTES-1] = in_data_byte;
      end
    end
    for (int j = 0; j < TAG_BYTES; j++) begin
      cmd_tag[8*j +: 8] = tag_nxt[j];
    end
  end

  assign cmd_ctl.hash      = hash;
  assign cmd_ctl.eop       = in_end_of_packet;
  assign cmd_ctl.vmode     = mode_r;
  assign cmd_ctl.short_pkt = (fill_nxt < FW'(TAG_BYTES));
  assign cmd_push          = accept && (hash || in_end_of_packet);

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r <= in_end_of_packet ? '0 : fill_nxt;
      end
    end
  end
endmodule

/* src/s1icv_back.sv */
// Back end: SHA-1 block buffer, round engine, padding, tag output and check.
module s1icv_back import s1icv_pkg::*; #(
  parameter int LENGTH_BITS = 16,
  parameter int TAG_BYTES   = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic [7:0]             cmd_byte,
  input  cmd_ctl_t               cmd_ctl,
  input  logic [TAG_BYTES*8-1:0] cmd_tag,
  input  logic                   out_full,
  output logic                   out_push,
  output out_item_t              out_item
);
  localparam int TW = $clog2(TAG_BYTES);

  typedef enum logic [7:0] {
    B_IDLE    = 8'b0000_0001,
    B_BYTE    = 8'b0000_0010,
    B_PADINIT = 8'b0000_0100,
    B_PAD     = 8'b0000_1000,
    B_ROUND   = 8'b0001_0000,
    B_FINAL   = 8'b0010_0000,
    B_TAG     = 8'b0100_0000,
    B_STAT    = 8'b1000_0000
  } bstate_t;

  bstate_t                state_r;
  logic [7:0]             byte_r;
  cmd_ctl_t               ctl_r;
  logic [TAG_BYTES*8-1:0] tag_r;
  logic [31:0]            blk_r [16];
  logic [31:0]            chain_r [5];
  logic [31:0]            a_r, b_r, c_r, d_r, e_r;
  logic [6:0]             rnd_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [5:0]             pos_r;
  logic                   first_r, lenph_r, padding_r, pad_done_r;
  logic [TW-1:0]          tidx_r;
  logic [31:0]            drops_r, drops_nxt;

  logic [31:0] f, k, t, w_new;
  logic [63:0] len_bits;
  logic [7:0]  len_byte, pad_byte;
  logic        pad_len, fail, tag_last;

  function automatic logic [7:0] dig_byte(input logic [4:0] i);
    logic [31:0] wd;
    wd = chain_r[i[4:2]];
    return wd[{~i[1:0], 3'b000} +: 8];
  endfunction

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = SHA_K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = SHA_K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = SHA_K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = SHA_K3;
    end
  end

  assign t        = {a_r[26:0], a_r[31:27]} + f + e_r + k + blk_r[0];
  assign w_new    = {1'b0, 31'b0} | ({(blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0])} << 1)
                  | ((blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0]) >> 31);
  assign len_bits = 64'(len_r) << 3;
  assign len_byte = len_bits[{~pos_r[2:0], 3'b000} +: 8];
  assign pad_len  = !first_r && (lenph_r || pos_r == LEN_POS);
  assign pad_byte = first_r ? PAD_MARK : (pad_len ? len_byte : 8'h00);
  assign tag_last = (tidx_r == TW'(TAG_BYTES - 1));

  always_comb begin
    fail = ctl_r.short_pkt;
    for (int j = 0; j < TAG_BYTES; j++) begin
      if (tag_r[8*j +: 8] != dig_byte(5'(j))) begin
        fail = 1'b1;
      end
    end
    drops_nxt = (fail && drops_r != '1) ? drops_r + 1'b1 : drops_r;
  end

  assign cmd_pop  = (state_r == B_IDLE) && !cmd_empty;
  assign out_push = !out_full &&
                    (state_r == B_BYTE || state_r == B_TAG || state_r == B_STAT);

  always_comb begin
    out_item = '{data: byte_r, valid: 1'b1, last: 1'b0, fail: 1'b0, drops: drops_r};
    if (state_r == B_TAG) begin
      out_item.data = dig_byte(5'(tidx_r));
      out_item.last = tag_last;
    end else if (state_r == B_STAT) begin
      out_item = '{data: 8'h00, valid: 1'b0, last: 1'b1, fail: fail, drops: drops_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      len_r   <= '0;
      drops_r <= '0;
      chain_r <= SHA_INIT;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!cmd_empty) begin
            byte_r  <= cmd_byte;
            ctl_r   <= cmd_ctl;
            tag_r   <= cmd_tag;
            state_r <= cmd_ctl.hash ? B_BYTE : B_PADINIT;
          end
        end
        B_BYTE: begin
          if (!out_full) begin
            blk_r[len_r[5:2]][{~len_r[1:0], 3'b000} +: 8] <= byte_r;
            len_r     <= len_r + 1'b1;
            padding_r <= 1'b0;
            if (len_r[5:0] == LAST_POS) begin
              {a_r, b_r, c_r, d_r, e_r} <=
                {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
              rnd_r   <= '0;
              state_r <= B_ROUND;
            end else begin
              state_r <= ctl_r.eop ? B_PADINIT : B_IDLE;
            end
          end
        end
        B_PADINIT: begin
          pos_r   <= len_r[5:0];
          first_r <= 1'b1;
          lenph_r <= 1'b0;
          state_r <= B_PAD;
        end
        B_PAD: begin
          blk_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= pad_byte;
          first_r <= 1'b0;
          if (pad_len) begin
            lenph_r <= 1'b1;
          end
          pos_r <= pos_r + 1'b1;
          if (pos_r == LAST_POS) begin
            {a_r, b_r, c_r, d_r, e_r} <=
              {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
            rnd_r      <= '0;
            padding_r  <= 1'b1;
            pad_done_r <= pad_len;
            state_r    <= B_ROUND;
          end
        end
        B_ROUND: begin
          e_r <= d_r;
          d_r <= c_r;
          c_r <= {b_r[1:0], b_r[31:2]};
          b_r <= a_r;
          a_r <= t;
          for (int i = 0; i < 15; i++) begin
            blk_r[i] <= blk_r[i+1];
          end
          blk_r[15] <= w_new;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == LAST_ROUND) begin
            state_r <= B_FINAL;
          end
        end
        B_FINAL: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          tidx_r     <= '0;
          if (padding_r) begin
            if (pad_done_r) begin
              state_r <= ctl_r.vmode ? B_STAT : B_TAG;
            end else begin
              state_r <= B_PAD;
            end
          end else begin
            state_r <= ctl_r.eop ? B_PADINIT : B_IDLE;
          end
        end
        B_TAG: begin
          if (!out_full) begin
            tidx_r <= tidx_r + 1'b1;
            if (tag_last) begin
              chain_r <= SHA_INIT;
              len_r   <= '0;
              state_r <= B_IDLE;
            end
          end
        end
        B_STAT: begin
          if (!out_full) begin
            drops_r <= drops_nxt;
            chain_r <= SHA_INIT;
            len_r   <= '0;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_push && out_full))
    else $error("result pushed into a full queue");

  a_drops_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> drops_r >= $past(drops_r))
    else $error("drop count went backwards");

  a_round_then_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND && rnd_r == LAST_ROUND) |=> state_r == B_FINAL)
    else $error("compression did not finish after the last round");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == B_BYTE || state_r == B_PADINIT))
    else $error("request taken outside the idle state");
endmodule

/* src/sha1_icv_append_verify_unit.sv */
// Top level: SHA-1 truncated tag append (compute mode) or check and strip (verify mode).
// A forwarded byte passes the command queue, the back end's byte register and the result
// queue; the back end takes no new request before the last is forwarded, and each 64-byte
// block adds a compression (80 rounds plus the chaining add). Packet end adds one padding
// byte per cycle between compressions, one or two compressions, then the tag or the verdict.
// Synchronous active-low reset: compute mode, empty queues, drop count zero.
module sha1_icv_append_verify_unit import s1icv_pkg::*; #(
  parameter int LENGTH_BITS = 16,
  parameter int TAG_BYTES   = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_packet,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_packet,
  output logic        out_auth_fail,
  output logic [31:0] out_drops_so_far
);
  localparam int CMD_W = 8 + $bits(cmd_ctl_t) + TAG_BYTES * 8;
  localparam int OUT_W = $bits(out_item_t);

  logic                   f_push, c_full, c_empty, c_pop;
  logic [7:0]             f_byte, b_byte;
  cmd_ctl_t               f_ctl, b_ctl;
  logic [TAG_BYTES*8-1:0] f_tag, b_tag;
  logic                   o_full, o_push;
  out_item_t              o_item, q_item;

  s1icv_front #(.TAG_BYTES(TAG_BYTES)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .push, .full,
    .in_data_byte, .in_end_of_packet,
    .cmd_push(f_push), .cmd_full(c_full), .cmd_byte(f_byte),
    .cmd_ctl(f_ctl), .cmd_tag(f_tag)
  );

  s1icv_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk, .rst_n,
    .wr_en(f_push), .wr_data({f_byte, f_ctl, f_tag}), .full(c_full),
    .rd_en(c_pop), .rd_data({b_byte, b_ctl, b_tag}), .empty(c_empty)
  );

  s1icv_back #(.LENGTH_BITS(LENGTH_BITS), .TAG_BYTES(TAG_BYTES)) u_back (
    .clk, .rst_n,
    .cmd_empty(c_empty), .cmd_pop(c_pop), .cmd_byte(b_byte),
    .cmd_ctl(b_ctl), .cmd_tag(b_tag),
    .out_full(o_full), .out_push(o_push), .out_item(o_item)
  );

  s1icv_fifo #(.WIDTH(OUT_W), .DEPTH(4)) u_out_q (
    .clk, .rst_n,
    .wr_en(o_push), .wr_data(o_item), .full(o_full),
    .rd_en(pop), .rd_data(q_item), .empty(empty)
  );

  assign out_byte           = q_item.data;
  assign out_byte_valid     = q_item.valid;
  assign out_last_of_packet = q_item.last;
  assign out_auth_fail      = q_item.fail;
  assign out_drops_so_far   = q_item.drops;
endmodule

/* sim/sha1_icv_append_verify_unit_test.sv */
// Testbench for the SHA-1 truncated tag append and verify unit.
`timescale 1ns / 1ps

module sha1_icv_append_verify_unit_test import s1icv_pkg::*;;

  localparam int TAG_LEN   = 12;
  localparam int DIG_LEN   = 20;
  localparam int SETTLE    = 400;
  localparam bit MODE_COMPUTE = 1'b0;
  localparam bit MODE_VERIFY  = 1'b1;

  class tag_scoreboard;
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [15:0] hlen;
    logic [7:0]  held [TAG_LEN];
    int unsigned fill;
    logic [31:0] drops;
    bit          vmode;
    out_item_t   due [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned fails_seen;

    function void clear_packet();
      foreach (chain[i]) chain[i] = SHA_INIT[i];
      foreach (blk[i]) blk[i] = '0;
      foreach (held[i]) held[i] = '0;
      hlen = '0;
      fill = 0;
    endfunction

    function void reset_all();
      vmode = MODE_COMPUTE;
      drops = '0;
      errors = 0;
      checked = 0;
      fails_seen = 0;
      due.delete();
      clear_packet();
    endfunction

    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++) begin
        x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {x[30:0], x[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = SHA_K0;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = SHA_K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = SHA_K2;
        end else begin
          f = b ^ c ^ d; k = SHA_K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void put(int pos, logic [7:0] v);
      blk[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
      if (pos == 63) compress();
    endfunction

    function void absorb(logic [7:0] v);
      put(int'(hlen[5:0]), v);
      hlen = hlen + 16'd1;
    endfunction

    // Pads the message, runs the last blocks and returns the full digest.
    function void digest(output logic [7:0] dig [DIG_LEN]);
      logic [63:0] bits;
      int pos;
      bits = {45'd0, hlen, 3'd0};
      pos = int'(hlen[5:0]);
      put(pos, PAD_MARK);
      pos = (pos + 1) % 64;
      while (pos != 56) begin
        put(pos, 8'h00);
        pos = (pos + 1) % 64;
      end
      for (int i = 0; i < 8; i++) put(56 + i, bits[(7 - i) * 8 +: 8]);
      for (int i = 0; i < DIG_LEN; i++) dig[i] = chain[i / 4][(3 - i % 4) * 8 +: 8];
    endfunction

    function void add_item(logic [7:0] v, bit valid, bit last, bit fail);
      out_item_t it;
      it.data = v;
      it.valid = valid;
      it.last = last;
      it.fail = fail;
      it.drops = drops;
      due.push_back(it);
    endfunction

    function void note_request(logic [7:0] b, bit eop);
      logic [7:0] dig [DIG_LEN];
      logic [7:0] old;
      bit bad;
      if (vmode == MODE_COMPUTE) begin
        absorb(b);
        add_item(b, 1'b1, 1'b0, 1'b0);
        if (eop) begin
          digest(dig);
          for (int i = 0; i < TAG_LEN; i++) add_item(dig[i], 1'b1, i == TAG_LEN - 1, 1'b0);
          clear_packet();
        end
        return;
      end
      if (fill < TAG_LEN) begin
        held[fill] = b;
        fill++;
      end else begin
        old = held[0];
        for (int i = 0; i < TAG_LEN - 1; i++) held[i] = held[i+1];
        held[TAG_LEN-1] = b;
        absorb(old);
        add_item(old, 1'b1, 1'b0, 1'b0);
      end
      if (eop) begin
        digest(dig);
        bad = fill < TAG_LEN;
        for (int i = 0; i < TAG_LEN; i++) if (held[i] != dig[i]) bad = 1'b1;
        if (bad && drops != 32'hFFFF_FFFF) drops++;
        if (bad) fails_seen++;
        add_item(8'h00, 1'b0, 1'b1, bad);
        clear_packet();
      end
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      field_check("out_byte", want.data, got.data);
      field_check("byte_valid", want.valid, got.valid);
      field_check("last_of_packet", want.last, got.last);
      field_check("auth_fail", want.fail, got.fail);
      field_check("drops_so_far", want.drops, got.drops);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_packet = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_of_packet;
  logic        out_auth_fail;
  logic [31:0] out_drops_so_far;

  tag_scoreboard tag_sb;
  tag_scoreboard tag_calc;
  bit            gaps_on = 1'b1;
  int unsigned   requests_sent = 0;
  int unsigned   packets_sent = 0;

  always #5 clk = ~clk;

  sha1_icv_append_verify_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .in_data_byte(in_data_byte),
    .in_end_of_packet(in_end_of_packet),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last_of_packet(out_last_of_packet),
    .out_auth_fail(out_auth_fail),
    .out_drops_so_far(out_drops_so_far)
  );

  initial begin
    tag_sb = new();
    tag_calc = new();
    tag_sb.reset_all();
    tag_calc.reset_all();
  end

  // Result side: random pop at each falling edge, check at the rising edge.
  initial begin
    forever begin
      @(negedge clk);
      pop = gaps_on ? ($urandom_range(99) >= 38) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      tag_sb.check_result({out_byte, out_byte_valid, out_last_of_packet,
                           out_auth_fail, out_drops_so_far});
  end

  task automatic push_byte(input logic [7:0] b, input bit eop);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 38) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_data_byte = b;
    in_end_of_packet = eop;
    do @(posedge clk); while (full);
    tag_sb.note_request(b, eop);
    requests_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q [$], input bit close);
    foreach (q[i]) push_byte(q[i], close && (i == q.size() - 1));
    if (close) packets_sent++;
  endtask

  // Waits for every expected result, then lets a held-back tail finish hashing.
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (tag_sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    tag_sb.vmode = m;
  endtask

  // Builds a payload plus its correct truncated tag.
  task automatic tagged_packet(input int len, output logic [7:0] q [$]);
    logic [7:0] dig [DIG_LEN];
    q.delete();
    tag_calc.clear_packet();
    for (int i = 0; i < len; i++) begin
      q.push_back(8'($urandom()));
      tag_calc.absorb(q[i]);
    end
    tag_calc.digest(dig);
    for (int i = 0; i < TAG_LEN; i++) q.push_back(dig[i]);
  endtask

  task automatic random_packet(input bit m, output logic [7:0] q [$]);
    int len;
    int pick;
    int spot;
    len = ($urandom_range(5) == 0) ? $urandom_range(130) : $urandom_range(20);
    pick = $urandom_range(99);
    if (m == MODE_COMPUTE) begin
      q.delete();
      for (int i = 0; i <= len; i++) q.push_back(8'($urandom()));
    end else if (pick < 10) begin
      q.delete();
      spot = $urandom_range(1, TAG_LEN - 1);
      for (int i = 0; i < spot; i++) q.push_back(8'($urandom()));
    end else begin
      tagged_packet(len, q);
      if (pick < 35) begin
        spot = $urandom_range(q.size() - 1);
        q[spot] = q[spot] ^ (8'h01 << $urandom_range(7));
      end
    end
  endtask

  initial begin
    logic [7:0] q [$];
    logic [7:0] part [$];
    bit m;
    int cut;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: single bytes at both extremes, a short message, then verify-mode
    // short packets and a packet that holds nothing but a correct tag.
    set_mode(MODE_COMPUTE);
    send_bytes('{8'h00}, 1'b1);
    send_bytes('{8'hFF}, 1'b1);
    send_bytes('{8'h61, 8'h62, 8'h63}, 1'b1);
    set_mode(MODE_VERIFY);
    send_bytes('{8'hFF}, 1'b1);
    send_bytes('{8'h00, 8'h5A, 8'hFF}, 1'b1);
    tagged_packet(0, q);
    send_bytes(q, 1'b1);

    m = MODE_VERIFY;
    while (requests_sent < 430) begin
      gaps_on = !(requests_sent >= 160 && requests_sent < 250);
      if ($urandom_range(3) == 0) begin
        m = !m;
        set_mode(m);
      end
      random_packet(m, q);
      if ($urandom_range(9) == 0 && q.size() > 2) begin
        // Mode flips in the middle of a packet.
        cut = $urandom_range(1, q.size() - 1);
        part = q[0:cut-1];
        send_bytes(part, 1'b0);
        m = !m;
        set_mode(m);
        part = q[cut:$];
        send_bytes(part, 1'b1);
      end else begin
        send_bytes(q, 1'b1);
      end
      if (packets_sent == 40) drain();
    end

    gaps_on = 1'b1;
    drain();
    $display("Sent %0d requests in %0d packets over both modes; %0d results checked,",
             requests_sent, packets_sent, tag_sb.checked);
    $display("%0d of them failed authentication by design.", tag_sb.fails_seen);
    if (tag_sb.errors == 0 && tag_sb.due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding.", tag_sb.due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
